>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRR_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRR_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> hw/rtl/srr_pkg.sv
// Types, constants and helpers for the selective-repeat receiver.
// No dependencies; every module in this folder imports it.
package srr_pkg;

  localparam int unsigned SEQ_W          = 3;
  localparam int unsigned PAYLOAD_W      = 32;
  localparam int unsigned WIN_W          = 3;
  localparam int unsigned SEQ_MAX_W      = 8;
  localparam int unsigned SEQ_SPACE_DEF  = 8;
  localparam int unsigned WINDOW_CAP     = 4;
  localparam int unsigned DRAIN_MAX      = 3;
  localparam int unsigned DRAIN_W        = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [WIN_W-1:0] WINDOW_RST = 3'd4;

  typedef enum logic {
    ACT_DELIVERED = 1'b0,
    ACT_BUFFERED  = 1'b1
  } srr_action_t;

  typedef enum logic {
    CMD_DELIVER = 1'b0,
    CMD_BUFFER  = 1'b1
  } srr_cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } srr_bk_state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]     frame_seq;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic                 crc_good;
  } srr_in_t;

  typedef struct packed {
    logic [SEQ_W-1:0]     ack_seq;
    srr_action_t          action;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 last;
  } srr_out_t;

  // Work handed from the classifier to the delivery side.
  typedef struct packed {
    srr_cmd_kind_t        kind;
    logic [SEQ_MAX_W-1:0] seq;
    logic [PAYLOAD_W-1:0] payload;
    logic [DRAIN_W-1:0]   drain;
  } srr_cmd_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } srr_qstat_t;

  // Sequence number increment modulo the sequence space.
  function automatic logic [SEQ_MAX_W-1:0] seq_inc(input logic [SEQ_MAX_W-1:0] x,
                                                   input int unsigned space);
    logic [SEQ_MAX_W:0] s;
    s = {1'b0, x} + (SEQ_MAX_W+1)'(1);
    if (32'(s) >= space) begin
      return '0;
    end
    return s[SEQ_MAX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/srr_front.sv
// Receiver front end: accepts frames, classifies them against the window and
// owns the expected number and held marks. Depends on srr_pkg, assert_macros.svh.
`include "assert_macros.svh"

module srr_front #(
  parameter int unsigned SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  srr_pkg::srr_in_t           in_data,
  input  logic [srr_pkg::WIN_W-1:0]  window,
  input  srr_pkg::srr_qstat_t        q_stat,
  output logic                       q_push,
  output srr_pkg::srr_cmd_t          q_cmd
);
  import srr_pkg::*;

  localparam int unsigned IW   = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
  localparam int unsigned HALF = SEQ_SPACE / 2;
  localparam int unsigned CAP  = (HALF > WINDOW_CAP) ? WINDOW_CAP :
                                 ((HALF < 1) ? 1 : HALF);
  localparam logic [IW:0] SPACE_V = (IW+1)'(SEQ_SPACE);

  logic [IW-1:0]        exp_r, exp_nxt;
  logic [SEQ_SPACE-1:0] marks_r, marks_nxt;

  logic          acc, in_range, is_order, is_buf, in_win;
  logic [IW-1:0] seq_i, e1, e2, e3, e4;
  logic [IW:0]   seq_gap;
  logic [WIN_W-1:0] win_eff;
  logic          m1, m2, m3;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;
  assign seq_i    = IW'(in_data.frame_seq);
  assign in_range = 32'(in_data.frame_seq) < SEQ_SPACE;

  assign e1 = IW'(seq_inc(SEQ_MAX_W'(exp_r), SEQ_SPACE));
  assign e2 = IW'(seq_inc(SEQ_MAX_W'(e1), SEQ_SPACE));
  assign e3 = IW'(seq_inc(SEQ_MAX_W'(e2), SEQ_SPACE));
  assign e4 = IW'(seq_inc(SEQ_MAX_W'(e3), SEQ_SPACE));

  // Consecutive held frames after the expected one, at most three.
  assign m1 = marks_r[e1];
  assign m2 = m1 && marks_r[e2];
  assign m3 = m2 && marks_r[e3];

  always_comb begin
    seq_gap = {1'b0, seq_i} - {1'b0, exp_r};
    if (seq_i < exp_r) begin
      seq_gap = seq_gap + SPACE_V;
    end
    win_eff = (window == '0) ? WIN_W'(1) : window;
    if (32'(win_eff) > CAP) begin
      win_eff = WIN_W'(CAP);
    end
  end

  assign in_win   = (seq_gap != '0) && (32'(seq_gap) < 32'(win_eff));
  assign is_order = in_range && in_data.crc_good && (seq_i == exp_r);
  assign is_buf   = in_range && in_data.crc_good && !is_order && in_win && !marks_r[seq_i];
  assign q_push   = acc && (is_order || is_buf);

  always_comb begin
    q_cmd.kind    = is_order ? CMD_DELIVER : CMD_BUFFER;
    q_cmd.seq     = SEQ_MAX_W'(seq_i);
    q_cmd.payload = in_data.frame_payload;
    q_cmd.drain   = DRAIN_W'(m1) + DRAIN_W'(m2) + DRAIN_W'(m3);
  end

  always_comb begin
    exp_nxt   = exp_r;
    marks_nxt = marks_r;
    if (acc && is_order) begin
      if (m1) marks_nxt[e1] = 1'b0;
      if (m2) marks_nxt[e2] = 1'b0;
      if (m3) marks_nxt[e3] = 1'b0;
      if (m3) begin
        exp_nxt = e4;
      end else if (m2) begin
        exp_nxt = e3;
      end else if (m1) begin
        exp_nxt = e2;
      end else begin
        exp_nxt = e1;
      end
    end else if (acc && is_buf) begin
      marks_nxt[seq_i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      marks_r <= '0;
    end else begin
      exp_r   <= exp_nxt;
      marks_r <= marks_nxt;
    end
  end

  // The slot of the expected frame is never held.
  `SRR_ASSERT_IMP(a_exp_unmarked, 1'b1, !marks_r[exp_r], "expected slot is marked")
  // A corrupted frame leaves the held marks alone.
  `SRR_ASSERT_NXT(a_bad_crc_keeps, acc && !in_data.crc_good, marks_r == $past(marks_r),
                  "corrupted frame changed marks")
  // The expected number moves only after an in-order frame was queued.
  `SRR_ASSERT_NXT(a_exp_moves, !(q_push && q_cmd.kind == CMD_DELIVER),
                  exp_r == $past(exp_r), "expected number moved without delivery")

endmodule

>>> hw/rtl/srr_queue.sv
// Short command queue between the receiver front end and delivery side.
// Depends on srr_pkg, assert_macros.svh.
`include "assert_macros.svh"

module srr_queue #(
  parameter int unsigned DEPTH = srr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  srr_pkg::srr_cmd_t   push_cmd,
  input  logic                pop,
  output srr_pkg::srr_cmd_t   head_cmd,
  output srr_pkg::srr_qstat_t stat
);
  import srr_pkg::*;

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  srr_cmd_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign head_cmd       = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SRR_ASSERT_IMP(a_no_push_full, push, !stat.full, "push into a full queue")
  `SRR_ASSERT_IMP(a_no_pop_empty, pop, stat.not_empty, "pop from an empty queue")
  `SRR_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_r) <= DEPTH, "queue count overflow")

endmodule

>>> hw/rtl/srr_back.sv
// Receiver delivery side: stores buffered words, sends acks and drains held
// frames from the payload store. Depends on srr_pkg, assert_macros.svh.
`include "assert_macros.svh"

module srr_back #(
  parameter int unsigned SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srr_pkg::srr_qstat_t q_stat,
  input  srr_pkg::srr_cmd_t   q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output srr_pkg::srr_out_t   out_data
);
  import srr_pkg::*;

  localparam int unsigned IW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;

  logic [PAYLOAD_W-1:0] store [SEQ_SPACE];

  srr_bk_state_t        state_r, state_nxt;
  logic [IW-1:0]        addr_r, addr_nxt;
  logic [DRAIN_W-1:0]   remain_r, remain_nxt;
  logic [PAYLOAD_W-1:0] rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  srr_out_t             out_data_r, load_data;
  logic                 out_free, load, mem_we;

  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_stat.not_empty && out_free && q_cmd.kind == CMD_DELIVER &&
            q_cmd.drain != '0) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: state_nxt = BK_SEND;
      BK_SEND: begin
        if (out_free) begin
          state_nxt = (remain_r == DRAIN_W'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    load       = 1'b0;
    load_data  = out_data_r;
    addr_nxt   = addr_r;
    remain_nxt = remain_r;
    case (state_r)
      BK_IDLE: begin
        if (q_stat.not_empty && out_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          load_data.ack_seq = SEQ_W'(q_cmd.seq);
          if (q_cmd.kind == CMD_BUFFER) begin
            mem_we                = 1'b1;
            load_data.action      = ACT_BUFFERED;
            load_data.out_payload = '0;
            load_data.last        = 1'b1;
          end else begin
            load_data.action      = ACT_DELIVERED;
            load_data.out_payload = q_cmd.payload;
            load_data.last        = (q_cmd.drain == '0);
            addr_nxt   = IW'(seq_inc(q_cmd.seq, SEQ_SPACE));
            remain_nxt = q_cmd.drain;
          end
        end
      end
      BK_SEND: begin
        if (out_free) begin
          load                  = 1'b1;
          load_data.ack_seq     = SEQ_W'(addr_r);
          load_data.action      = ACT_DELIVERED;
          load_data.out_payload = rd_data_r;
          load_data.last        = (remain_r == DRAIN_W'(1));
          addr_nxt   = IW'(seq_inc(SEQ_MAX_W'(addr_r), SEQ_SPACE));
          remain_nxt = remain_r - DRAIN_W'(1);
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[IW'(q_cmd.seq)] <= q_cmd.payload;
    end
    rd_data_r <= store[addr_r];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
    addr_r   <= addr_nxt;
    remain_r <= remain_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SRR_ASSERT_IMP(a_no_overwrite, out_valid_r && out_stall, !load,
                  "result overwritten while stalled")
  `SRR_ASSERT_IMP(a_drain_count, state_r != BK_IDLE, remain_r != '0,
                  "drain running with nothing left")
  `SRR_ASSERT_NXT(a_buffer_ack, mem_we,
                  out_valid_r && out_data_r.action == ACT_BUFFERED && out_data_r.last,
                  "buffered frame not acked")

endmodule

>>> hw/rtl/selective_repeat_receiver_top.sv
// Top level of the selective-repeat ARQ receiver: window register, front end,
// command queue and delivery side. Depends on srr_pkg and the srr_* modules.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   srr_in_t   (one frame)
//   out_     output     out_valid / out_stall srr_out_t  (one ack result)
//   cfg_     input      cfg_valid / cfg_ready window width, 3 bits
//
// The front end takes one frame per cycle while the two-entry queue has room.
// The delivery side handles a buffered or lone in-order frame in BK_IDLE and
// takes each drained held frame through BK_READ (store read), then BK_SEND.
// Synchronous active-low reset clears the expected number and the held marks
// in flip-flops at once; there is no clearing pass. A stalled result holds the
// output register, the queue then fills and in_stall rises.
module selective_repeat_receiver_top #(
  parameter int unsigned SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  srr_pkg::srr_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output srr_pkg::srr_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [srr_pkg::WIN_W-1:0] cfg_data
);
  import srr_pkg::*;

  logic [WIN_W-1:0] window_r;
  logic             q_push, q_pop;
  srr_cmd_t         push_cmd, head_cmd;
  srr_qstat_t       q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_data;
    end
  end

  srr_front #(.SEQ_SPACE(SEQ_SPACE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .window   (window_r),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  srr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  srr_back #(.SEQ_SPACE(SEQ_SPACE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
